// ===== design/segint_pkg.sv =====
// Package for the segment intersection test core.
// Holds the default coordinate width and the per-item mode flags.
// No dependencies.
package segint_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	typedef struct packed {
		logic vert;
		logic kill;
	} segint_mode_t;

endpackage

// ===== design/segment_intersection_test_core.sv =====
// Segment intersection test: four register stages (operand set-up, products, differences,
// compares into the result register). Throughput one request per cycle while hit_stall
// is low; the six product lanes in stage 2 set the clock.
// Stalls back up stage by stage, so bubbles are squeezed out before pair_stall rises.
// arst_n clears the stage valid bits only; data registers are not reset.
// Depends on segint_pkg.
module segment_intersection_test_core
	import segint_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  logic signed [COORD_WIDTH-1:0] seg1_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg1_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg1_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg1_end_y,
	input  logic signed [COORD_WIDTH-1:0] seg2_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg2_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg2_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg2_end_y,
	output logic                          hit_valid,
	input  logic                          hit_stall,
	output logic                          hit
);

	localparam int DW    = COORD_WIDTH + 1;
	localparam int PW    = 2 * DW;
	localparam int AW    = PW + 1;
	localparam int LANES = 6;

	function automatic logic signed [DW-1:0] sx(input logic signed [COORD_WIDTH-1:0] v);
		return {v[COORD_WIDTH-1], v};
	endfunction

	// handshake / enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4        = !v_s4 || !hit_stall;
	assign en3        = !v_s3 || en4;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign pair_stall = !en1;
	assign hit_valid  = v_s4;

	// stage 1: differences and operand select
	logic                   v1, v2, out_of_range;
	logic signed [COORD_WIDTH-1:0] vx, vy0, vy1, osx, osy, oex, oey;
	logic signed [COORD_WIDTH-1:0] ox_lo, ox_hi, vy_lo, vy_hi;
	logic signed [DW-1:0]   d1x, d1y, d2x, d2y, wx, wy;
	logic signed [DW-1:0]   q, n, dy, lo, hi;
	logic signed [DW-1:0]   opa_d [LANES];
	logic signed [DW-1:0]   opb_d [LANES];
	segint_mode_t           mode_d;

	always_comb begin
		d1x = sx(seg1_end_x) - sx(seg1_start_x);
		d1y = sx(seg1_end_y) - sx(seg1_start_y);
		d2x = sx(seg2_end_x) - sx(seg2_start_x);
		d2y = sx(seg2_end_y) - sx(seg2_start_y);
		wx  = sx(seg2_start_x) - sx(seg1_start_x);
		wy  = sx(seg2_start_y) - sx(seg1_start_y);
		v1  = (seg1_start_x == seg1_end_x);
		v2  = (seg2_start_x == seg2_end_x);

		if (v1) begin
			vx  = seg1_start_x;
			vy0 = seg1_start_y;
			vy1 = seg1_end_y;
			osx = seg2_start_x;
			osy = seg2_start_y;
			oex = seg2_end_x;
			oey = seg2_end_y;
		end else begin
			vx  = seg2_start_x;
			vy0 = seg2_start_y;
			vy1 = seg2_end_y;
			osx = seg1_start_x;
			osy = seg1_start_y;
			oex = seg1_end_x;
			oey = seg1_end_y;
		end

		ox_lo        = (osx < oex) ? osx : oex;
		ox_hi        = (osx < oex) ? oex : osx;
		vy_lo        = (vy0 < vy1) ? vy0 : vy1;
		vy_hi        = (vy0 < vy1) ? vy1 : vy0;
		out_of_range = (vx < ox_lo) || (vx > ox_hi);

		// run direction folded into q so that q >= 0
		if (oex >= osx) begin
			q = sx(oex) - sx(osx);
			n = sx(vx) - sx(osx);
		end else begin
			q = sx(osx) - sx(oex);
			n = sx(osx) - sx(vx);
		end
		dy = sx(oey) - sx(osy);
		lo = sx(vy_lo) - sx(osy);
		hi = sx(vy_hi) - sx(osy);

		mode_d.vert = v1 || v2;
		mode_d.kill = (v1 && v2) || ((v1 || v2) && out_of_range);

		if (mode_d.vert) begin
			// lane0 - lane1 = m - lower, lane2 - lane3 = upper - m
			opa_d[0] = dy;  opb_d[0] = n;
			opa_d[1] = lo;  opb_d[1] = q;
			opa_d[2] = hi;  opb_d[2] = q;
			opa_d[3] = dy;  opb_d[3] = n;
		end else begin
			opa_d[0] = d1x; opb_d[0] = d2y;
			opa_d[1] = d1y; opb_d[1] = d2x;
			opa_d[2] = wx;  opb_d[2] = d2y;
			opa_d[3] = wy;  opb_d[3] = d2x;
		end
		opa_d[4] = wx;  opb_d[4] = d1y;
		opa_d[5] = wy;  opb_d[5] = d1x;
	end

	logic signed [DW-1:0] opa_s1 [LANES];
	logic signed [DW-1:0] opb_s1 [LANES];
	segint_mode_t         mode_s1, mode_s2, mode_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			opa_s1  <= opa_d;
			opb_s1  <= opb_d;
			mode_s1 <= mode_d;
		end
	end

	// stage 2: products
	logic signed [PW-1:0] prod_s2 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < LANES; i++) begin
				prod_s2[i] <= opa_s1[i] * opb_s1[i];
			end
			mode_s2 <= mode_s1;
		end
	end

	// stage 3: den / tn / un (or the two vertical margins)
	logic signed [AW-1:0] den_s3, tn_s3, un_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			den_s3  <= AW'(prod_s2[0]) - AW'(prod_s2[1]);
			tn_s3   <= AW'(prod_s2[2]) - AW'(prod_s2[3]);
			un_s3   <= AW'(prod_s2[4]) - AW'(prod_s2[5]);
			mode_s3 <= mode_s2;
		end
	end

	// stage 4: range compares into the result register
	logic hit_d;
	logic hit_s4;

	always_comb begin
		if (mode_s3.kill) begin
			hit_d = 1'b0;
		end else if (mode_s3.vert) begin
			hit_d = !den_s3[AW-1] && !tn_s3[AW-1];
		end else if (den_s3 == '0) begin
			hit_d = 1'b0;
		end else if (!den_s3[AW-1]) begin
			hit_d = !tn_s3[AW-1] && (tn_s3 <= den_s3) &&
			        !un_s3[AW-1] && (un_s3 <= den_s3);
		end else begin
			hit_d = (tn_s3[AW-1] || (tn_s3 == '0)) && (tn_s3 >= den_s3) &&
			        (un_s3[AW-1] || (un_s3 == '0)) && (un_s3 >= den_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			hit_s4 <= hit_d;
		end
	end

	assign hit = hit_s4;

endmodule

// ===== bench/segment_intersection_test_core_tb.sv =====
// Self-checking bench for segment_intersection_test_core: a queue-fed driver, a monitor and
// an exact integer predictor of the hit flag, with random idling on both channels.
// Depends on segint_pkg and the core itself.
`timescale 1ns / 1ps

module testbench;
	import segint_pkg::*;

	localparam int CW        = COORD_WIDTH_DEF;
	localparam int N_RANDOM  = 1300;
	localparam int RUN_LIMIT = 200000;
	localparam int TAIL_LEN  = 100;

	typedef struct {
		logic signed [CW-1:0] s1x, s1y, e1x, e1y;
		logic signed [CW-1:0] s2x, s2y, e2x, e2y;
	} seg_pair_t;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      pair_valid = 1'b0;
	logic      hit_stall  = 1'b0;
	logic      quiet_tail = 1'b0;
	logic      pair_stall;
	logic      hit_valid;
	logic      hit;
	seg_pair_t cur_pair   = '{default: '0};

	seg_pair_t pending[$];
	bit        expected_hits[$];
	int        cycle_count   = 0;
	int        fault_count   = 0;
	int        results_seen  = 0;
	int        hits_seen     = 0;
	int        pairs_sent    = 0;
	int        n_directed    = 0;
	int        send_gap      = 0;
	int        send_idle_pct = 0;
	int        stall_left    = 0;
	int        stall_pct     = 0;

	segment_intersection_test_core #(
		.COORD_WIDTH(CW)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pair_valid  (pair_valid),
		.pair_stall  (pair_stall),
		.seg1_start_x(cur_pair.s1x),
		.seg1_start_y(cur_pair.s1y),
		.seg1_end_x  (cur_pair.e1x),
		.seg1_end_y  (cur_pair.e1y),
		.seg2_start_x(cur_pair.s2x),
		.seg2_start_y(cur_pair.s2y),
		.seg2_end_x  (cur_pair.e2x),
		.seg2_end_y  (cur_pair.e2y),
		.hit_valid   (hit_valid),
		.hit_stall   (hit_stall),
		.hit         (hit)
	);

	always #1 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// vertical segment at x = vx against a non-vertical segment, compared as rationals
	function automatic bit crosses_vertical(longint vx, longint vy0, longint vy1,
			longint sx, longint sy, longint ex, longint ey);
		longint run, off, rise, m, lo, hi;
		if (vx < ((sx < ex) ? sx : ex) || vx > ((sx > ex) ? sx : ex))
			return 1'b0;
		run  = ex - sx;
		off  = vx - sx;
		rise = ey - sy;
		if (run < 0) begin
			run = -run;
			off = -off;
		end
		m  = rise * off;
		lo = (((vy0 < vy1) ? vy0 : vy1) - sy) * run;
		hi = (((vy0 > vy1) ? vy0 : vy1) - sy) * run;
		return lo <= m && m <= hi;
	endfunction

	function automatic bit segments_meet(seg_pair_t p);
		longint ax = p.s1x, ay = p.s1y, bx = p.e1x, by = p.e1y;
		longint cx = p.s2x, cy = p.s2y, dx = p.e2x, dy = p.e2y;
		longint d1x = bx - ax, d1y = by - ay;
		longint d2x = dx - cx, d2y = dy - cy;
		longint wx = cx - ax, wy = cy - ay;
		longint den, tn, un;
		if (d1x == 0 && d2x == 0)
			return 1'b0;
		if (d1x == 0)
			return crosses_vertical(ax, ay, by, cx, cy, dx, dy);
		if (d2x == 0)
			return crosses_vertical(cx, cy, dy, ax, ay, bx, by);
		den = d1x * d2y - d1y * d2x;
		tn  = wx * d2y - wy * d2x;
		un  = wx * d1y - wy * d1x;
		if (den == 0)
			return 1'b0;
		if (den < 0) begin
			den = -den;
			tn  = -tn;
			un  = -un;
		end
		return tn >= 0 && tn <= den && un >= 0 && un <= den;
	endfunction

	function automatic seg_pair_t pair_of(int a, int b, int c, int d,
			int e, int f, int g, int h);
		seg_pair_t p;
		p.s1x = a[CW-1:0];
		p.s1y = b[CW-1:0];
		p.e1x = c[CW-1:0];
		p.e1y = d[CW-1:0];
		p.s2x = e[CW-1:0];
		p.s2y = f[CW-1:0];
		p.e2x = g[CW-1:0];
		p.e2y = h[CW-1:0];
		return p;
	endfunction

	function automatic int spread(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic seg_pair_t random_pair();
		int c[8];
		int px, py, sx, sy, k, j, m, lo, hi, vx, yl, t;
		for (int i = 0; i < 8; i++)
			c[i] = spread(20000);
		case ($urandom_range(0, 9))
			0, 1: begin
				for (int i = 0; i < 8; i++)
					c[i] = int'($urandom);
			end
			2, 3: begin
				for (int i = 0; i < 8; i++)
					c[i] = spread(8);
			end
			4: begin
				for (int i = 0; i < 8; i++)
					c[i] = spread(1000);
			end
			5: begin
				// vertical through the other line; one end near the crossing, the other near or random
				lo = (c[0] < c[2]) ? c[0] : c[2];
				hi = (c[0] > c[2]) ? c[0] : c[2];
				vx = lo + int'($urandom_range(0, hi - lo));
				yl = (c[0] == c[2]) ? c[1] : c[1] + (c[3] - c[1]) * (vx - c[0]) / (c[2] - c[0]);
				c[4] = vx;
				c[6] = vx;
				c[5] = yl - int'($urandom_range(0, 3)) + ($urandom_range(0, 3) == 0);
				c[7] = ($urandom_range(0, 1)) ? yl + int'($urandom_range(0, 3)) : spread(20000);
			end
			6, 7: begin
				// lattice line: touching, collinear or offset-parallel partner
				px = spread(15000);
				py = spread(15000);
				sx = spread(40);
				sy = spread(40);
				k  = $urandom_range(1, 20);
				j  = $urandom_range(0, k);
				m  = $urandom_range(0, 8);
				c[0] = px;
				c[1] = py;
				c[2] = px + k * sx;
				c[3] = py + k * sy;
				case ($urandom_range(0, 2))
					0: begin
						c[4] = px + j * sx;
						c[5] = py + j * sy;
					end
					1: begin
						c[4] = px + j * sx;
						c[5] = py + j * sy;
						c[6] = px + (j + m) * sx;
						c[7] = py + (j + m) * sy;
					end
					default: begin
						c[4] = c[0] + spread(3);
						c[5] = c[1] + spread(3);
						c[6] = c[4] + c[2] - c[0];
						c[7] = c[5] + c[3] - c[1];
					end
				endcase
			end
			8: begin
				// degenerate point, on the other segment half the time
				px = spread(15000);
				py = spread(15000);
				sx = spread(40);
				sy = spread(40);
				k  = $urandom_range(1, 20);
				j  = $urandom_range(0, k);
				c[0] = px;
				c[1] = py;
				c[2] = px + k * sx;
				c[3] = py + k * sy;
				if ($urandom_range(0, 1)) begin
					c[4] = px + j * sx;
					c[5] = py + j * sy;
				end
				c[6] = c[4];
				c[7] = c[5];
			end
			default: begin
				// axis-aligned pieces on a small grid
				c[0] = spread(20);
				c[1] = spread(20);
				c[2] = spread(20);
				c[3] = c[1];
				c[4] = spread(20);
				c[5] = spread(20);
				c[6] = c[4];
				c[7] = spread(20);
			end
		endcase
		if ($urandom_range(0, 1)) begin
			for (int i = 0; i < 4; i++) begin
				t        = c[i];
				c[i]     = c[i + 4];
				c[i + 4] = t;
			end
		end
		if ($urandom_range(0, 1)) begin
			t = c[0]; c[0] = c[2]; c[2] = t;
			t = c[1]; c[1] = c[3]; c[3] = t;
		end
		if ($urandom_range(0, 1)) begin
			t = c[4]; c[4] = c[6]; c[6] = t;
			t = c[5]; c[5] = c[7]; c[7] = t;
		end
		return pair_of(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid <= 1'b0;
			quiet_tail <= 1'b0;
			send_gap = 0;
		end else begin
			if (pair_valid && !pair_stall) begin
				expected_hits.push_back(segments_meet(cur_pair));
				pairs_sent++;
			end
			if (cycle_count % 64 == 0)
				send_idle_pct = pick_idle_pct();
			if (!pair_valid || !pair_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					pair_valid <= 1'b0;
				end else if (pending.size() != 0 && !quiet_tail &&
						$urandom_range(0, 99) < send_idle_pct) begin
					send_gap = $urandom_range(0, 6);
					pair_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					cur_pair   <= pending.pop_front();
					pair_valid <= 1'b1;
				end else begin
					pair_valid <= 1'b0;
				end
			end
			quiet_tail <= pending.size() < TAIL_LEN;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			hit_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (hit_valid && !hit_stall) begin
				results_seen++;
				if (expected_hits.size() == 0) begin
					if (fault_count < 10)
						$display("result %0d arrived with no request outstanding",
							results_seen);
					fault_count++;
				end else begin
					want = expected_hits.pop_front();
					if (hit !== want) begin
						if (fault_count < 10)
							$display("hit mismatch on result %0d: expected %0b, got %b",
								results_seen, want, hit);
						fault_count++;
					end
					if (want)
						hits_seen++;
				end
			end
			if (cycle_count % 64 == 32)
				stall_pct = pick_idle_pct();
			if (stall_left > 0) begin
				stall_left--;
				hit_stall <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 6);
				hit_stall <= 1'b1;
			end else begin
				hit_stall <= 1'b0;
			end
		end
	end

	initial begin
		pending.push_back(pair_of(-10, -10, 10, 10, -10, 10, 10, -10));
		pending.push_back(pair_of(5, 0, 5, 10, 5, 5, 5, 20));
		pending.push_back(pair_of(5, 0, 5, 10, 7, 0, 7, 10));
		pending.push_back(pair_of(0, 0, 10, 10, 0, 1, 10, 11));
		pending.push_back(pair_of(0, 0, 10, 10, 5, 5, 15, 15));
		pending.push_back(pair_of(0, 0, 10, 0, 0, 0, 10, 0));
		pending.push_back(pair_of(3, 3, 3, 3, 0, 0, 10, 10));
		pending.push_back(pair_of(3, 4, 3, 4, 0, 0, 10, 10));
		pending.push_back(pair_of(3, 3, 3, 3, 3, 3, 3, 3));
		pending.push_back(pair_of(0, 0, 5, 5, 5, 5, 10, 0));
		pending.push_back(pair_of(0, 0, 10, 0, 5, 0, 5, 10));
		pending.push_back(pair_of(0, 0, 10, 0, 5, 1, 5, 10));
		pending.push_back(pair_of(0, 0, 1, 1, 5, 0, 6, 3));
		pending.push_back(pair_of(0, 0, 10, 10, 0, 10, 4, 6));
		pending.push_back(pair_of(0, 0, 10, 10, 0, 10, 5, 5));
		pending.push_back(pair_of(10, 10, -10, -10, 10, -10, -10, 10));
		pending.push_back(pair_of(20, 0, -20, 10, 0, -5, 0, 20));
		pending.push_back(pair_of(-32768, -32768, 32767, 32767,
			-32768, 32767, 32767, -32768));
		pending.push_back(pair_of(-32768, 32767, 32767, 32767,
			32767, -32768, 32767, 32767));
		pending.push_back(pair_of(-32768, -32768, 32767, -32767,
			-32767, 32767, -32767, -32768));
		pending.push_back(pair_of(32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767));
		pending.push_back(pair_of(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768));
		pending.push_back(pair_of(-32768, 0, 32767, 1, -32768, 1, 32767, 0));
		pending.push_back(pair_of(16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
			16'h5555, 16'h5555, 16'haaaa, 16'haaaa));
		n_directed = pending.size();
		for (int i = 0; i < N_RANDOM; i++)
			pending.push_back(random_pair());
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pending.size() != 0 || pair_valid)
			@(posedge clk);
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d segment pairs sent (%0d directed), %0d results checked, %0d hits",
			pairs_sent, n_directed, results_seen, hits_seen);
		$display("%0d mismatches in %0d cycles", fault_count, cycle_count);
		if (fault_count == 0)
			$display("segment_intersection_test_core verification clean");
		else
			$display("segment_intersection_test_core verification failed");
		$finish;
	end

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("run stopped at cycle limit %0d with %0d results outstanding",
			RUN_LIMIT, expected_hits.size());
		$display("segment_intersection_test_core verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/segint_pkg.sv
design/segment_intersection_test_core.sv
bench/segment_intersection_test_core_tb.sv
